>>> hw/rtl/cgg_pkg.sv
// ----------------------------------------------------------------------------
// Color gradient generator package
// Shared types and constants for the gradient pipeline.
// ----------------------------------------------------------------------------
package cgg_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_GRADIENT_MODE = 3'd2,
    REG_INNER_COLOR   = 3'd3,
    REG_OUTER_COLOR   = 3'd4
  } reg_index_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_DIM_W  = 13;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int LIN_Q_W    = CH_W + 1;
  localparam int RAD_Q_W    = 2 * FRAC_W + 1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
  localparam logic [CH_W-1:0]     CH_MAX     = '1;

  // Control bits that travel with a pixel through the pipeline.
  typedef struct packed {
    logic valid;
    logic range_err;
    logic w_one;
    logic mode;
  } side_t;

endpackage

>>> hw/rtl/cgg_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; requires num < den << QUO_W.
// ----------------------------------------------------------------------------
module cgg_div_pipe #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 11,
  parameter int QUO_W = 9
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // Stage registers: partial remainder, unused dividend bits, quotient so far.
  logic [DEN_W-1:0] rem_q [1:QUO_W];
  logic [QUO_W-1:0] low_q [1:QUO_W];
  logic [QUO_W-1:0] quo_q [1:QUO_W];
  logic [DEN_W-1:0] den_q [1:QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = DEN_W'(num >> QUO_W);
      assign low_in = num[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_rest
      assign rem_in = rem_q[i];
      assign low_in = low_q[i];
      assign quo_in = quo_q[i];
      assign den_in = den_q[i];
    end

    // Shift in the next dividend bit and try a subtraction.
    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_q[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_q[i+1] <= {low_in[QUO_W-2:0], 1'b0};
      quo_q[i+1] <= {quo_in[QUO_W-2:0], ge};
      den_q[i+1] <= den_in;
    end
  end

  assign quo = quo_q[QUO_W];

endmodule

>>> hw/rtl/cgg_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module cgg_isqrt_pipe #(
  parameter int VAL_W = 33
) (
  input  logic           clk,
  input  logic [VAL_W-1:0] radicand,
  output logic [VAL_W:0]   root
);

  localparam int STEPS = (VAL_W + 1) / 2;

  logic [VAL_W-1:0] val_q [1:STEPS];
  logic [VAL_W:0]   res_q [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [VAL_W:0] BIT = (VAL_W + 1)'(1) << (2 * (STEPS - 1 - i));
    logic [VAL_W-1:0] val_in;
    logic [VAL_W:0]   res_in;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   rem;
    logic             ge;

    if (i == 0) begin : g_first
      assign val_in = radicand;
      assign res_in = '0;
    end else begin : g_rest
      assign val_in = val_q[i];
      assign res_in = res_q[i];
    end

    // Subtract the trial square when it fits and set the current root bit.
    assign trial = res_in + BIT;
    assign ge    = {1'b0, val_in} >= trial;
    assign rem   = {1'b0, val_in} - trial;

    always_ff @(posedge clk) begin
      val_q[i+1] <= ge ? rem[VAL_W-1:0] : val_in;
      res_q[i+1] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end
  end

  assign root = res_q[STEPS];

endmodule

>>> hw/rtl/cgg_delay.sv
// ----------------------------------------------------------------------------
// Delay line
// Fixed-length shift register that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module cgg_delay #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [0:DEPTH-1];

  // Each tap loads from the one before it; reset flushes valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        taps[i] <= '0;
      end
    end else begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

>>> hw/rtl/color_gradient_generator_unit.sv
// ----------------------------------------------------------------------------
// Color gradient generator
// Linear or radial RGBA gradient, one pixel coordinate in, one color out.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock; busy is high only during reset.
// The radial path sets the latency: a 33-stage divider and a 17-stage root.
// Reset: dimensions 1x1, linear mode, both colors zero, pipeline flushed.
// Results cannot be stalled; done marks each result for one cycle.
module color_gradient_generator_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cgg_pkg::COORD_W-1:0]     pos_x,
  input  logic [cgg_pkg::COORD_W-1:0]     pos_y,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cgg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cgg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output logic [cgg_pkg::CH_W-1:0]        red,
  output logic [cgg_pkg::CH_W-1:0]        green,
  output logic [cgg_pkg::CH_W-1:0]        blue,
  output logic [cgg_pkg::CH_W-1:0]        alpha,
  output logic                            range_error
);

  localparam int CH_W     = cgg_pkg::CH_W;
  localparam int NUM_CH   = cgg_pkg::NUM_CH;
  localparam int DW       = $clog2(MAX_DIM + 1);
  localparam int AW       = (DW > cgg_pkg::COORD_W + 1 ? DW : cgg_pkg::COORD_W + 1) + 1;
  localparam int SQ_W     = 2 * DW;
  localparam int RW       = SQ_W + 1;
  localparam int PROD_W   = CH_W + DW;
  localparam int LNUM_W   = DW + CH_W + 2;
  localparam int LDEN_W   = DW + 1;
  localparam int LQ_W     = cgg_pkg::LIN_Q_W;
  localparam int RQ_W     = cgg_pkg::RAD_Q_W;
  localparam int RNUM_W   = RW + RQ_W - 1;
  localparam int WW       = cgg_pkg::WEIGHT_W;
  localparam int BPROD_W  = CH_W + WW;
  localparam int SQRT_D   = (RQ_W + 1) / 2;
  localparam int SIDE_D   = RQ_W + SQRT_D;
  localparam int LIN_D    = SIDE_D - LQ_W;
  localparam int LATENCY  = 3 + SIDE_D + 2;

  // Configuration registers.
  logic [cgg_pkg::CFG_DIM_W-1:0] image_width;
  logic [cgg_pkg::CFG_DIM_W-1:0] image_height;
  logic                          gradient_mode;
  logic [cgg_pkg::COLOR_W-1:0]   inner_color;
  logic [cgg_pkg::COLOR_W-1:0]   outer_color;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  // Configuration write decode; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= cgg_pkg::CFG_DIM_W'(1);
      image_height  <= cgg_pkg::CFG_DIM_W'(1);
      gradient_mode <= 1'b0;
      inner_color   <= '0;
      outer_color   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cgg_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[cgg_pkg::CFG_DIM_W-1:0];
        cgg_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[cgg_pkg::CFG_DIM_W-1:0];
        cgg_pkg::REG_GRADIENT_MODE: gradient_mode <= cfg_data[0];
        cgg_pkg::REG_INNER_COLOR:   inner_color   <= cfg_data;
        cgg_pkg::REG_OUTER_COLOR:   outer_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions saturated to the supported maximum.
  logic [DW-1:0] dim_w;
  logic [DW-1:0] dim_h;
  assign dim_w = (32'(image_width) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(image_width);
  assign dim_h = (32'(image_height) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(image_height);

  function automatic int COLOR_POS(input int k);
    return (NUM_CH - 1 - k) * CH_W;
  endfunction

  // Channel views of the two colors, red first.
  logic [NUM_CH-1:0][CH_W-1:0] inner_ch;
  logic [NUM_CH-1:0][CH_W-1:0] outer_ch;
  for (genvar k = 0; k < NUM_CH; k++) begin : g_chan
    assign inner_ch[k] = inner_color[COLOR_POS(k) +: CH_W];
    assign outer_ch[k] = outer_color[COLOR_POS(k) +: CH_W];
  end

  // Front stage: range check and center offsets in doubled coordinates.
  logic [AW-1:0] x2p1;
  logic [AW-1:0] y2p1;
  logic [AW-1:0] dx_abs;
  logic [AW-1:0] dy_abs;
  assign x2p1   = AW'({pos_x, 1'b1});
  assign y2p1   = AW'({pos_y, 1'b1});
  assign dx_abs = (x2p1 >= AW'(dim_w)) ? x2p1 - AW'(dim_w) : AW'(dim_w) - x2p1;
  assign dy_abs = (y2p1 >= AW'(dim_h)) ? y2p1 - AW'(dim_h) : AW'(dim_h) - y2p1;

  cgg_pkg::side_t side1;
  logic [DW-1:0]  dx1;
  logic [DW-1:0]  dy1;
  logic [DW-1:0]  xs1;
  logic [DW-1:0]  dmx1;
  logic [DW-1:0]  wm1_1;
  logic [DW-1:0]  hm1_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      side1 <= '0;
    end else begin
      side1.valid     <= start && !busy;
      side1.range_err <= (32'(pos_x) >= 32'(dim_w)) || (32'(pos_y) >= 32'(dim_h));
      side1.w_one     <= dim_w == DW'(1);
      side1.mode      <= gradient_mode;
    end
    dx1   <= DW'(dx_abs);
    dy1   <= DW'(dy_abs);
    xs1   <= DW'(pos_x);
    dmx1  <= (dim_w - DW'(1)) - DW'(pos_x);
    wm1_1 <= dim_w - DW'(1);
    hm1_1 <= dim_h - DW'(1);
  end

  // Second stage: squares and linear blend products.
  cgg_pkg::side_t side2;
  logic [SQ_W-1:0] sqx2;
  logic [SQ_W-1:0] sqy2;
  logic [SQ_W-1:0] sqw2;
  logic [SQ_W-1:0] sqh2;
  logic [DW-1:0]   wm1_2;
  logic [NUM_CH-1:0][PROD_W-1:0] pin2;
  logic [NUM_CH-1:0][PROD_W-1:0] pout2;

  always_ff @(posedge clk) begin
    if (rst) begin
      side2 <= '0;
    end else begin
      side2 <= side1;
    end
    sqx2  <= SQ_W'(dx1) * SQ_W'(dx1);
    sqy2  <= SQ_W'(dy1) * SQ_W'(dy1);
    sqw2  <= SQ_W'(wm1_1) * SQ_W'(wm1_1);
    sqh2  <= SQ_W'(hm1_1) * SQ_W'(hm1_1);
    wm1_2 <= wm1_1;
    for (int k = 0; k < NUM_CH; k++) begin
      pin2[k]  <= PROD_W'(inner_ch[k]) * PROD_W'(dmx1);
      pout2[k] <= PROD_W'(outer_ch[k]) * PROD_W'(xs1);
    end
  end

  // Third stage: dividends and divisors for both gradient modes.
  cgg_pkg::side_t side3;
  logic [RW-1:0]     d2_3;
  logic [RW-1:0]     r2_3;
  logic [LDEN_W-1:0] lden3;
  logic [NUM_CH-1:0][LNUM_W-1:0] lnum3;

  always_ff @(posedge clk) begin
    if (rst) begin
      side3 <= '0;
    end else begin
      side3 <= side2;
    end
    d2_3  <= RW'(sqx2) + RW'(sqy2);
    r2_3  <= RW'(sqw2) + RW'(sqh2);
    lden3 <= {wm1_2, 1'b0};
    for (int k = 0; k < NUM_CH; k++) begin
      lnum3[k] <= {(LNUM_W - 1)'(pin2[k]) + (LNUM_W - 1)'(pout2[k]), 1'b0}
                + LNUM_W'(wm1_2);
    end
  end

  // Radial path: d2 * 2^32 / r2, then the square root gives the weight.
  logic [RNUM_W-1:0] rnum;
  logic [RQ_W-1:0]   rquo;
  logic [RQ_W:0]     root;
  assign rnum = {d2_3, {(RQ_W - 1){1'b0}}};

  cgg_div_pipe #(
    .NUM_W (RNUM_W),
    .DEN_W (RW),
    .QUO_W (RQ_W)
  ) u_rad_div (
    .clk (clk),
    .num (rnum),
    .den (r2_3),
    .quo (rquo)
  );

  cgg_isqrt_pipe #(
    .VAL_W (RQ_W)
  ) u_rad_sqrt (
    .clk      (clk),
    .radicand (rquo),
    .root     (root)
  );

  // Linear path: one rounding divider per channel, then aligned to the root.
  logic [NUM_CH-1:0][LQ_W-1:0] lquo;
  logic [NUM_CH-1:0][LQ_W-1:0] lquo_d;

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lin
    cgg_div_pipe #(
      .NUM_W (LNUM_W),
      .DEN_W (LDEN_W),
      .QUO_W (LQ_W)
    ) u_lin_div (
      .clk (clk),
      .num (lnum3[k]),
      .den (lden3),
      .quo (lquo[k])
    );
  end

  cgg_delay #(
    .WIDTH (NUM_CH * LQ_W),
    .DEPTH (LIN_D)
  ) u_lin_delay (
    .clk  (clk),
    .rst  (rst),
    .din  (lquo),
    .dout (lquo_d)
  );

  cgg_pkg::side_t side_d;
  cgg_delay #(
    .WIDTH ($bits(cgg_pkg::side_t)),
    .DEPTH (SIDE_D)
  ) u_side_delay (
    .clk  (clk),
    .rst  (rst),
    .din  (side3),
    .dout (side_d)
  );

  // Blend stage one: radial weight products.
  logic [WW-1:0] w16;
  logic [WW-1:0] w16_inv;
  assign w16     = (root > (RQ_W + 1)'(cgg_pkg::WEIGHT_ONE)) ? cgg_pkg::WEIGHT_ONE
                                                            : root[WW-1:0];
  assign w16_inv = cgg_pkg::WEIGHT_ONE - w16;

  cgg_pkg::side_t side_a;
  logic [NUM_CH-1:0][BPROD_W-1:0] bin_a;
  logic [NUM_CH-1:0][BPROD_W-1:0] bout_a;
  logic [NUM_CH-1:0][LQ_W-1:0]    lquo_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a <= '0;
    end else begin
      side_a <= side_d;
    end
    lquo_a <= lquo_d;
    for (int k = 0; k < NUM_CH; k++) begin
      bin_a[k]  <= BPROD_W'(inner_ch[k]) * BPROD_W'(w16_inv);
      bout_a[k] <= BPROD_W'(outer_ch[k]) * BPROD_W'(w16);
    end
  end

  // Blend stage two: rounding, clamping and selection of the result.
  logic [NUM_CH-1:0][BPROD_W:0]  bsum;
  logic [NUM_CH-1:0][CH_W-1:0]   chan_next;
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      bsum[k] = (BPROD_W + 1)'(bin_a[k]) + (BPROD_W + 1)'(bout_a[k])
              + ((BPROD_W + 1)'(1) << (cgg_pkg::FRAC_W - 1));
      if (side_a.range_err) begin
        chan_next[k] = '0;
      end else if (side_a.w_one) begin
        chan_next[k] = inner_ch[k];
      end else if (side_a.mode) begin
        chan_next[k] = (bsum[k][BPROD_W:cgg_pkg::FRAC_W]
                        > (BPROD_W + 1 - cgg_pkg::FRAC_W)'(cgg_pkg::CH_MAX))
                     ? cgg_pkg::CH_MAX : bsum[k][cgg_pkg::FRAC_W +: CH_W];
      end else begin
        chan_next[k] = (lquo_a[k] > LQ_W'(cgg_pkg::CH_MAX)) ? cgg_pkg::CH_MAX
                                                            : lquo_a[k][CH_W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_a.valid;
    end
    red         <= chan_next[0];
    green       <= chan_next[1];
    blue        <= chan_next[2];
    alpha       <= chan_next[3];
    range_error <= side_a.range_err;
  end

  // An accepted transaction yields its result a fixed time later.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  // Every result comes from an accepted transaction.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // An out-of-range pixel carries zero color.
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (red == '0 && green == '0 && blue == '0 && alpha == '0))
    else $error("out-of-range result with nonzero color");

endmodule
